// ===== rtl/dhcpp_pkg.sv =====
// shared types and constants for the dhcp option parser
package dhcpp_pkg;

  localparam int DEF_MAX_AREA_BYTES = 2048;

  // result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  localparam int VALUE_BYTES = 4;

  // option codes of interest
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_END       = 8'd255;
  localparam logic [7:0] OPT_TYPE      = 8'd53;
  localparam logic [7:0] OPT_OVERLOAD  = 8'd52;
  localparam logic [7:0] OPT_SERVER    = 8'd54;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_HOST_NAME = 8'd12;
  localparam logic [7:0] OPT_CLIENT_ID = 8'd61;
  localparam logic [7:0] OPT_GATEWAY   = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;

  // result kinds
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // end reasons
  localparam logic [1:0] REASON_END_CODE  = 2'd0;
  localparam logic [1:0] REASON_RAN_OUT   = 2'd1;
  localparam logic [1:0] REASON_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic       area_start;
    logic       area_last;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  option_code;
    logic [7:0]  option_length;
    logic [10:0] data_offset;
    logic [7:0]  message_type;
    logic [7:0]  overload_flags;
    logic [31:0] server_address;
    logic [31:0] lease_seconds;
    logic [7:0]  found_mask;
    logic [1:0]  end_reason;
    logic        last;
  } result_t;

endpackage

// ===== rtl/dhcp_option_tlv_parser.sv =====
// dhcp option area parser: one byte per item, option records and area summaries out
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata data_byte, s_tuser flags, s_tlast area_last
//  m_*      out  m_tvalid/m_tready  m_tdata result fields, m_tuser result_kind, m_tlast last
//
//  one byte accepted per cycle while the result side keeps up; a byte waits in the
//  input register until the queue has room for a pair, then its results are pushed
//  a byte may cause two results, so a run of such bytes is limited by the one
//  result per cycle output port; the four-entry result queue sets the slack
//  rst clears parse state, held values and queue; nothing is lost on stalls
module dhcp_option_tlv_parser import dhcpp_pkg::*; #(
  parameter int MAX_AREA_BYTES = DEF_MAX_AREA_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic [1:0]   s_tuser,   // message_start, area_start
  input  logic         s_tlast,   // area_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // option_code, option_length, data_offset,
                                  // message_type, overload_flags, server_address,
                                  // lease_seconds, found_mask, end_reason, zero pad
  output logic         m_tuser,   // result_kind
  output logic         m_tlast    // last
);

  logic          in_valid;
  item_t         in_item;
  logic          fire;
  logic          has_room;
  result_t [1:0] res;
  logic    [1:0] res_count;
  logic    [1:0] push_count;
  result_t       out_res;

  assign fire       = in_valid & has_room;
  assign s_tready   = ~in_valid | fire;
  assign push_count = fire ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data_byte     <= s_tdata;
      in_item.message_start <= s_tuser[0];
      in_item.area_start    <= s_tuser[1];
      in_item.area_last     <= s_tlast;
    end
  end

  dhcpp_core #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (in_item),
    .res      (res),
    .res_count(res_count)
  );

  dhcpp_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {3'd0, out_res.end_reason, out_res.found_mask, out_res.lease_seconds,
                    out_res.server_address, out_res.overload_flags, out_res.message_type,
                    out_res.data_offset, out_res.option_length, out_res.option_code};
  assign m_tuser = out_res.result_kind;
  assign m_tlast = out_res.last;

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_item)))
    else $error("held item lost while waiting for queue room");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_SUMMARY) |-> (m_tlast && m_tdata[26:0] == 27'd0))
    else $error("summary carries option fields or is not last");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_RECORD) |-> (m_tdata[116:115] == REASON_END_CODE))
    else $error("option record carries an end reason");

  assert property (@(posedge clk) disable iff (rst)
    (fire && res_count == 2'd2) |-> (res[0].result_kind == KIND_RECORD && !res[0].last))
    else $error("pair of results not ordered record then summary");

endmodule

// ===== rtl/dhcpp_core.sv =====
// parse state and per-byte update, up to two results per item
module dhcpp_core import dhcpp_pkg::*; #(
  parameter int MAX_AREA_BYTES = DEF_MAX_AREA_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  item_t         item,
  output result_t [1:0] res,
  output logic    [1:0] res_count
);

  localparam int POS_W = $clog2(MAX_AREA_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_AREA_BYTES - 1);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_DATA,
    PH_DONE
  } phase_t;

  phase_t           parse_phase, parse_phase_next;
  logic [7:0]       current_code, current_code_next;
  logic [7:0]       current_length, current_length_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [POS_W-1:0] area_position, area_position_next;
  logic [POS_W-1:0] option_start, option_start_next;
  logic [31:0]      value_shift, value_shift_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_overload, held_overload_next;
  logic [31:0]      held_server, held_server_next;
  logic [31:0]      held_lease, held_lease_next;
  logic [7:0]       seen_bits, seen_bits_next;

  logic [POS_W-1:0] pos;
  logic             done;
  logic [31:0]      value_word;
  logic [7:0]       consumed;
  logic [1:0]       reason;
  logic [POS_W+10:0] start_ext;
  result_t          rec, summ;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    sat_inc = (p == POS_MAX) ? p : p + POS_W'(1);
  endfunction

  always_comb begin
    parse_phase_next    = parse_phase;
    current_code_next   = current_code;
    current_length_next = current_length;
    bytes_left_next     = bytes_left;
    option_start_next   = option_start;
    value_shift_next    = value_shift;
    held_type_next      = held_type;
    held_overload_next  = held_overload;
    held_server_next    = held_server;
    held_lease_next     = held_lease;
    seen_bits_next      = seen_bits;
    done                = 1'b0;
    value_word          = '0;
    reason              = REASON_END_CODE;
    consumed            = current_length - bytes_left;

    if (item.message_start) begin
      held_type_next     = '0;
      held_overload_next = '0;
      held_server_next   = '0;
      held_lease_next    = '0;
      seen_bits_next     = '0;
    end

    if (item.area_start) begin
      parse_phase_next = PH_CODE;
      pos              = '0;
    end else begin
      pos = area_position;
    end

    case (parse_phase_next)
      PH_CODE: begin
        if (item.data_byte == OPT_END) begin
          parse_phase_next = PH_DONE;
        end else if (item.data_byte != OPT_PAD) begin
          current_code_next = item.data_byte;
          value_shift_next  = '0;
          parse_phase_next  = PH_LEN;
        end
      end
      PH_LEN: begin
        current_length_next = item.data_byte;
        bytes_left_next     = item.data_byte;
        option_start_next   = sat_inc(pos);
        if (item.data_byte == 8'd0) begin
          done = 1'b1;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (consumed < 8'(VALUE_BYTES)) begin
          value_shift_next = {value_shift[23:0], item.data_byte};
        end
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // short options read as if the missing bytes were zero
    if (current_length_next >= 8'(VALUE_BYTES)) begin
      value_word = value_shift_next;
    end else begin
      case (current_length_next[1:0])
        2'd1:    value_word = {value_shift_next[7:0], 24'd0};
        2'd2:    value_word = {value_shift_next[15:0], 16'd0};
        2'd3:    value_word = {value_shift_next[23:0], 8'd0};
        default: value_word = '0;
      endcase
    end

    if (done) begin
      parse_phase_next = PH_CODE;
      case (current_code_next)
        OPT_TYPE: begin
          held_type_next    = value_word[31:24];
          seen_bits_next[0] = 1'b1;
        end
        OPT_OVERLOAD: begin
          held_overload_next = value_word[31:24];
          seen_bits_next[1]  = 1'b1;
        end
        OPT_SERVER: begin
          held_server_next  = value_word;
          seen_bits_next[2] = 1'b1;
        end
        OPT_LEASE: begin
          held_lease_next   = value_word;
          seen_bits_next[3] = 1'b1;
        end
        OPT_HOST_NAME: seen_bits_next[4] = 1'b1;
        OPT_CLIENT_ID: seen_bits_next[5] = 1'b1;
        OPT_GATEWAY:   seen_bits_next[6] = 1'b1;
        OPT_DNS:       seen_bits_next[7] = 1'b1;
        default: begin
        end
      endcase
    end

    if (item.area_last) begin
      case (parse_phase_next)
        PH_DONE: reason = REASON_END_CODE;
        PH_CODE: reason = REASON_RAN_OUT;
        default: reason = REASON_TRUNCATED;
      endcase
      parse_phase_next = PH_CODE;
    end

    area_position_next = sat_inc(pos);
  end

  assign start_ext = {11'd0, option_start_next};

  always_comb begin
    rec.result_kind    = KIND_RECORD;
    rec.option_code    = current_code_next;
    rec.option_length  = current_length_next;
    rec.data_offset    = start_ext[10:0];
    rec.message_type   = held_type_next;
    rec.overload_flags = held_overload_next;
    rec.server_address = held_server_next;
    rec.lease_seconds  = held_lease_next;
    rec.found_mask     = seen_bits_next;
    rec.end_reason     = REASON_END_CODE;
    rec.last           = ~item.area_last;

    summ               = rec;
    summ.result_kind   = KIND_SUMMARY;
    summ.option_code   = '0;
    summ.option_length = '0;
    summ.data_offset   = '0;
    summ.end_reason    = reason;
    summ.last          = 1'b1;

    res[0]    = done ? rec : summ;
    res[1]    = summ;
    res_count = {1'b0, done} + {1'b0, item.area_last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_CODE;
      current_code   <= '0;
      current_length <= '0;
      bytes_left     <= '0;
      area_position  <= '0;
      option_start   <= '0;
      value_shift    <= '0;
      held_type      <= '0;
      held_overload  <= '0;
      held_server    <= '0;
      held_lease     <= '0;
      seen_bits      <= '0;
    end else if (fire) begin
      parse_phase    <= parse_phase_next;
      current_code   <= current_code_next;
      current_length <= current_length_next;
      bytes_left     <= bytes_left_next;
      area_position  <= area_position_next;
      option_start   <= option_start_next;
      value_shift    <= value_shift_next;
      held_type      <= held_type_next;
      held_overload  <= held_overload_next;
      held_server    <= held_server_next;
      held_lease     <= held_lease_next;
      seen_bits      <= seen_bits_next;
    end
  end

endmodule

// ===== rtl/dhcpp_rq.sv =====
// small result queue taking up to two results a cycle, one out
module dhcpp_rq import dhcpp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic    [1:0] push_count,
  input  result_t [1:0] push_data,
  output logic          has_room,
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       out_data
);

  result_t [RQ_DEPTH-1:0] slots;
  logic [RQ_AW-1:0]       wptr, rptr;
  logic [RQ_CW-1:0]       count;
  logic                   pop;
  logic [RQ_AW-1:0]       wptr_plus;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_data  = slots[rptr];
  // room for a full pair, whatever leaves this cycle
  assign has_room  = (count <= RQ_CW'(RQ_DEPTH - 2));
  assign wptr_plus = wptr + RQ_AW'(1);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      slots[wptr_plus] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RQ_AW'(push_count);
      rptr  <= rptr + RQ_AW'(pop);
      count <= count + RQ_CW'(push_count) - RQ_CW'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue over full");

  assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> (count <= RQ_CW'(RQ_DEPTH - 2)))
    else $error("push without room for a pair");

  assert property (@(posedge clk) disable iff (rst)
    (pop && push_count == 2'd0) |=> (count == $past(count) - RQ_CW'(1)))
    else $error("queue count lost track of a pop");

endmodule

// ===== bench/tb_dhcp_option_tlv_parser.sv =====
// testbench for the dhcp option area parser: directed and random byte streams checked against a predictor
module tb_dhcp_option_tlv_parser;
  import dhcpp_pkg::*;

  localparam int MAX_POS = DEF_MAX_AREA_BYTES - 1;

  typedef enum logic [1:0] {
    PH_EXPECT_CODE,
    PH_EXPECT_LEN,
    PH_IN_DATA,
    PH_STOPPED
  } parse_phase_t;

  typedef struct {
    item_t bits;
    bit    hold;   // wait until every expected result has come before sending
  } pending_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic [1:0]   s_tuser = 2'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  dhcp_option_tlv_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser state as seen by the predictor
  parse_phase_t phase = PH_EXPECT_CODE;
  logic [7:0]   cur_code = 8'd0;
  logic [7:0]   cur_len = 8'd0;
  logic [7:0]   bytes_left = 8'd0;
  int           area_pos = 0;
  int           opt_start = 0;
  logic [31:0]  value_acc = 32'd0;
  logic [7:0]   held_type = 8'd0;
  logic [7:0]   held_overload = 8'd0;
  logic [31:0]  held_server = 32'd0;
  logic [31:0]  held_lease = 32'd0;
  logic [7:0]   seen_bits = 8'd0;

  pending_byte_t pending_bytes[$];
  result_t       expected_results[$];
  int            errors = 0;

  function automatic int clip_position(int p);
    return (p > MAX_POS) ? MAX_POS : p;
  endfunction

  function automatic result_t make_result(logic kind, logic [7:0] code, logic [7:0] len,
                                          int off, logic [1:0] reason);
    result_t r;
    r.result_kind    = kind;
    r.option_code    = code;
    r.option_length  = len;
    r.data_offset    = off[10:0];
    r.message_type   = held_type;
    r.overload_flags = held_overload;
    r.server_address = held_server;
    r.lease_seconds  = held_lease;
    r.found_mask     = seen_bits;
    r.end_reason     = reason;
    r.last           = 1'b0;
    return r;
  endfunction

  // works out the results that one accepted byte causes
  task automatic parse_option_byte(input item_t it);
    result_t    outs[2];
    int         n_out;
    int         pos;
    int         k;
    bit         done;
    logic [1:0] reason;
    logic [31:0] w;
    n_out = 0;
    done = 1'b0;
    if (it.message_start) begin
      held_type = 8'd0;
      held_overload = 8'd0;
      held_server = 32'd0;
      held_lease = 32'd0;
      seen_bits = 8'd0;
    end
    if (it.area_start) begin
      phase = PH_EXPECT_CODE;
      pos = 0;
    end else begin
      pos = clip_position(area_pos);
    end
    case (phase)
      PH_EXPECT_CODE: begin
        if (it.data_byte == OPT_END) begin
          phase = PH_STOPPED;
        end else if (it.data_byte != OPT_PAD) begin
          cur_code = it.data_byte;
          value_acc = 32'd0;
          phase = PH_EXPECT_LEN;
        end
      end
      PH_EXPECT_LEN: begin
        cur_len = it.data_byte;
        bytes_left = it.data_byte;
        opt_start = clip_position(pos + 1);
        if (it.data_byte == 8'd0) done = 1'b1;
        else phase = PH_IN_DATA;
      end
      PH_IN_DATA: begin
        if (int'(cur_len) - int'(bytes_left) < VALUE_BYTES)
          value_acc = {value_acc[23:0], it.data_byte};
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) done = 1'b1;
      end
      default: ;
    endcase

    if (done) begin
      phase = PH_EXPECT_CODE;
      // missing data bytes of a short option read as zero at the low end
      k = (cur_len < VALUE_BYTES) ? int'(cur_len) : VALUE_BYTES;
      w = (k == 0) ? 32'd0 : value_acc << (8 * (VALUE_BYTES - k));
      case (cur_code)
        OPT_TYPE:      begin held_type = w[31:24];     seen_bits[0] = 1'b1; end
        OPT_OVERLOAD:  begin held_overload = w[31:24]; seen_bits[1] = 1'b1; end
        OPT_SERVER:    begin held_server = w;          seen_bits[2] = 1'b1; end
        OPT_LEASE:     begin held_lease = w;           seen_bits[3] = 1'b1; end
        OPT_HOST_NAME: seen_bits[4] = 1'b1;
        OPT_CLIENT_ID: seen_bits[5] = 1'b1;
        OPT_GATEWAY:   seen_bits[6] = 1'b1;
        OPT_DNS:       seen_bits[7] = 1'b1;
        default: ;
      endcase
      outs[n_out] = make_result(KIND_RECORD, cur_code, cur_len, opt_start, REASON_END_CODE);
      n_out++;
    end

    if (it.area_last) begin
      if (phase == PH_STOPPED) reason = REASON_END_CODE;
      else if (phase == PH_EXPECT_CODE) reason = REASON_RAN_OUT;
      else reason = REASON_TRUNCATED;
      phase = PH_EXPECT_CODE;
      outs[n_out] = make_result(KIND_SUMMARY, 8'd0, 8'd0, 0, reason);
      n_out++;
    end

    if (n_out > 0) outs[n_out-1].last = 1'b1;
    for (int i = 0; i < n_out; i++) expected_results.push_back(outs[i]);
    area_pos = clip_position(pos + 1);
  endtask

  // ---------------- stimulus ----------------

  task automatic add_byte(logic [7:0] b, bit ms, bit a_st, bit a_end, bit hold = 1'b0);
    pending_byte_t p;
    p.bits.data_byte = b;
    p.bits.message_start = ms;
    p.bits.area_start = a_st;
    p.bits.area_last = a_end;
    p.hold = hold;
    pending_bytes.push_back(p);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0: return OPT_TYPE;
      1: return OPT_OVERLOAD;
      2: return OPT_SERVER;
      3: return OPT_LEASE;
      4: return OPT_HOST_NAME;
      5: return OPT_CLIENT_ID;
      6: return OPT_GATEWAY;
      7: return OPT_DNS;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  // one options area; huge builds an area long enough to saturate the position
  task automatic add_area(bit new_msg, bit with_start, bit huge, bit hold);
    logic [7:0] area_bytes[$];
    logic [7:0] code;
    int         n_opt;
    int         len;
    int         cut;
    bit         ms;
    bit         a_st;
    n_opt = huge ? 9 : $urandom_range(0, 6);
    for (int i = 0; i < n_opt; i++) begin
      if (!huge && $urandom_range(0, 4) == 0) area_bytes.push_back(OPT_PAD);
      code = pick_code();
      if (huge) len = 255;
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 255);
      else len = $urandom_range(0, 6);
      area_bytes.push_back(code);
      area_bytes.push_back(8'(len));
      for (int j = 0; j < len; j++) area_bytes.push_back(8'($urandom));
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        area_bytes.push_back(OPT_END);
        repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom));
      end
      2: if (area_bytes.size() == 0) area_bytes.push_back(OPT_PAD);
      default: begin
        // option cut off by the end of the area
        area_bytes.push_back(pick_code());
        cut = $urandom_range(0, 2);
        if (cut > 0) begin
          len = $urandom_range(1, 10);
          area_bytes.push_back(8'(len));
          if (cut == 2)
            repeat ($urandom_range(0, len - 1)) area_bytes.push_back(8'($urandom));
        end
      end
    endcase
    foreach (area_bytes[i]) begin
      ms = (new_msg && i == 0) || (!huge && $urandom_range(0, 49) == 0);
      a_st = (with_start && i == 0) || (!huge && $urandom_range(0, 99) == 0);
      add_byte(area_bytes[i], ms, a_st, i == area_bytes.size() - 1, hold && i == 0);
    end
  endtask

  task automatic build_stimulus();
    int  first_random;
    bit  long_done;
    // message with type, short server, long lease, zero-length type, end code
    add_byte(OPT_TYPE, 1, 1, 0); add_byte(8'd1, 0, 0, 0); add_byte(8'd5, 0, 0, 0);
    add_byte(OPT_PAD, 0, 0, 0);
    add_byte(OPT_SERVER, 0, 0, 0); add_byte(8'd2, 0, 0, 0);
    add_byte(8'hAA, 0, 0, 0); add_byte(8'hBB, 0, 0, 0);
    add_byte(OPT_LEASE, 0, 0, 0); add_byte(8'd6, 0, 0, 0);
    add_byte(8'h01, 0, 0, 0); add_byte(8'h02, 0, 0, 0); add_byte(8'h03, 0, 0, 0);
    add_byte(8'h04, 0, 0, 0); add_byte(8'h05, 0, 0, 0); add_byte(8'h06, 0, 0, 0);
    add_byte(OPT_TYPE, 0, 0, 0); add_byte(8'd0, 0, 0, 0);
    // bytes after the end code are ignored
    add_byte(OPT_END, 0, 0, 0); add_byte(8'h77, 0, 0, 0); add_byte(8'hFF, 0, 0, 1);
    // code byte as the area's last byte
    add_byte(OPT_GATEWAY, 0, 1, 1);
    // area of a single pad runs out
    add_byte(OPT_PAD, 0, 1, 1);
    // new area begins mid-option, then an option finishes on the last byte
    add_byte(OPT_HOST_NAME, 0, 1, 0); add_byte(8'd5, 0, 0, 0); add_byte(8'h41, 0, 0, 0);
    add_byte(OPT_CLIENT_ID, 0, 1, 0); add_byte(8'd1, 0, 0, 0); add_byte(8'h09, 0, 0, 1);

    first_random = pending_bytes.size();
    long_done = 1'b0;
    add_area(1, 1, 0, 1);
    while (pending_bytes.size() - first_random < 600) begin
      if (!long_done && pending_bytes.size() - first_random > 300) begin
        add_area(1, 1, 1, 0);
        long_done = 1'b1;
        first_random += pending_bytes.size() - first_random - 300;
      end else if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 8))
          add_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                   $urandom_range(0, 5) == 0);
      end else begin
        add_area(1, 1, 0, $urandom_range(0, 19) == 0);
        // overloaded file or sname areas, sometimes without a start flag
        while ($urandom_range(0, 3) == 0) add_area(0, $urandom_range(0, 9) != 0, 0, 0);
      end
    end
  endtask

  // ---------------- driver ----------------

  item_t cur_item;
  int    burst_left = 1;
  int    gap_left = 0;

  always @(posedge clk) begin
    pending_byte_t nxt;
    logic          nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        parse_option_byte(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && expected_results.size() > 0)) begin
          nxt = pending_bytes.pop_front();
          cur_item = nxt.bits;
          s_tdata <= nxt.bits.data_byte;
          s_tuser <= {nxt.bits.area_start, nxt.bits.message_start};
          s_tlast <= nxt.bits.area_last;
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= nv;
    end
  end

  // ---------------- monitor ----------------

  int rx_mode = 0;
  int rx_cycle = 0;
  int rx_stall = 0;

  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic    rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.result_kind    = m_tuser;
        got.option_code    = m_tdata[7:0];
        got.option_length  = m_tdata[15:8];
        got.data_offset    = m_tdata[26:16];
        got.message_type   = m_tdata[34:27];
        got.overload_flags = m_tdata[42:35];
        got.server_address = m_tdata[74:43];
        got.lease_seconds  = m_tdata[106:75];
        got.found_mask     = m_tdata[114:107];
        got.end_reason     = m_tdata[116:115];
        got.last           = m_tlast;
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected result: %p", got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
            errors++;
          end
        end
      end
      // receiver alternates between always ready, random and long stalls
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 9) < 7);
        default: begin
          if (rx_stall > 0) begin
            rx_stall--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 12);
          end
        end
      endcase
      rx_cycle++;
      if (rx_cycle % 400 == 0) rx_mode = $urandom_range(0, 2);
      m_tready <= rdy;
    end
  end

  // ---------------- run control ----------------

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_bytes.size() > 0 || s_tvalid || expected_results.size() > 0);
    repeat (16) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
